>>> src/tct_pkg.sv
// shared types and constants for the t-way coverage tracker
// no dependencies; imported by every module of the block
package tct_pkg;

  localparam int MAX_PARAMS   = 8;
  localparam int LEVEL_BITS   = 2;
  localparam int MAX_STRENGTH = 3;
  localparam int MAP_ROWS     = 56;   // 3584 bits as 56 words of 64
  localparam int WORD_BITS    = 64;

  localparam logic [1:0] REG_PARAM_COUNT = 2'd0;
  localparam logic [1:0] REG_STRENGTH    = 2'd1;
  localparam logic [1:0] REG_LEVELS      = 2'd2;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_EVAL   = 2'd1;
  localparam logic [1:0] ACT_COMMIT = 2'd2;
  localparam logic [1:0] ACT_SPARE  = 2'd3;   // unused code, treated as evaluate

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_EVAL,
    CMD_COMMIT,
    CMD_ERROR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] test_vector;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  param_count;
    logic [1:0]  strength;
    logic [15:0] level_counts;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } back_state_t;

  function automatic logic [3:0] eff_params(input logic [3:0] pc);
    eff_params = (pc > 4'(MAX_PARAMS)) ? 4'(MAX_PARAMS) : pc;
  endfunction

endpackage

>>> src/tct_front.sv
// front end: accepts test items, checks values against level counts, queues them
// depends on tct_pkg
module tct_front import tct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] test_vector,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_ready
);

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       bad;
  cmd_t       new_cmd;
  logic       push, pop;
  logic [3:0] p;

  always_comb begin
    p   = eff_params(cfg.param_count);
    bad = 1'b0;
    for (int i = 0; i < MAX_PARAMS; i++) begin
      if (4'(i) < p &&
          test_vector[i*LEVEL_BITS +: LEVEL_BITS] > cfg.level_counts[i*LEVEL_BITS +: LEVEL_BITS])
        bad = 1'b1;
    end
    new_cmd.test_vector = test_vector;
    if (action == ACT_CLEAR)       new_cmd.kind = CMD_CLEAR;
    else if (bad)                  new_cmd.kind = CMD_ERROR;
    else if (action == ACT_COMMIT) new_cmd.kind = CMD_COMMIT;
    else                           new_cmd.kind = CMD_EVAL;
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_valid & in_ready;
  assign pop       = cmd_valid & cmd_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= new_cmd;
  end

endmodule

>>> src/tct_back.sv
// back end: walks parameter subsets over the coverage bitmap and holds the counts
// depends on tct_pkg; owns the bitmap memory and the result register
module tct_back import tct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  newly_covered,
  output logic [11:0] remaining,
  output logic [11:0] total,
  output logic        error
);

  back_state_t state_r, state_nxt;
  logic [WORD_BITS-1:0] mem [MAP_ROWS];
  logic [WORD_BITS-1:0] rdw_r;
  cmd_t        cmd_r, cmd_nxt;
  logic [2:0]  pos_r [MAX_STRENGTH];
  logic [2:0]  pos_nxt [MAX_STRENGTH];
  logic [2:0]  pos_adv [MAX_STRENGTH];
  logic [5:0]  row_r, row_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [5:0]  clr_row_r, clr_row_nxt;
  logic        clr_fin_r, clr_fin_nxt;
  logic        walk_fin_r, walk_fin_nxt;
  logic [11:0] uncov_r, uncov_nxt;
  logic [11:0] tot_r, tot_nxt;
  logic [5:0]  wa_r;
  logic [5:0]  bit_r;
  logic        out_valid_r, out_valid_nxt;
  logic [5:0]  newly_r, newly_nxt;
  logic [11:0] rem_out_r, rem_out_nxt;
  logic [11:0] tot_out_r, tot_out_nxt;
  logic        err_r, err_nxt;

  logic [3:0]  p;
  logic [1:0]  t;
  logic        empty;
  logic        more;
  logic [1:0]  sel;
  logic [7:0]  idx, prod;
  logic [2:0]  lv;
  logic [11:0] row_sh, addr;
  logic        mem_we;
  logic [5:0]  mem_wa;
  logic [WORD_BITS-1:0] mem_wd;

  // lexicographic successor of the current subset, its value index, level product and bitmap address
  always_comb begin
    p     = eff_params(cfg.param_count);
    t     = cfg.strength;
    empty = (t == 2'd0) || ({2'b0, t} > p);
    more  = 1'b0;
    sel   = 2'd0;
    for (int i = 0; i < MAX_STRENGTH; i++) pos_adv[i] = pos_r[i];
    for (int i = MAX_STRENGTH - 1; i >= 0; i--) begin
      if (!more && 2'(i) < t && {1'b0, pos_r[i]} != p - {2'b0, t} + 4'(i)) begin
        more       = 1'b1;
        sel        = 2'(i);
        pos_adv[i] = pos_r[i] + 3'd1;
      end
    end
    for (int j = 1; j < MAX_STRENGTH; j++) begin
      if (more && 2'(j) > sel) pos_adv[j] = pos_adv[j-1] + 3'd1;
    end
    idx  = 8'd0;
    prod = 8'd1;
    for (int k = 0; k < MAX_STRENGTH; k++) begin
      lv = {1'b0, cfg.level_counts[{pos_r[k], 1'b0} +: LEVEL_BITS]} + 3'd1;
      if (2'(k) < t) begin
        idx  = idx * {5'd0, lv} + {6'd0, cmd_r.test_vector[{pos_r[k], 1'b0} +: LEVEL_BITS]};
        prod = prod * {5'd0, lv};
      end
    end
    case (t)
      2'd1:    row_sh = {6'd0, row_r} << 2;
      2'd2:    row_sh = {6'd0, row_r} << 4;
      2'd3:    row_sh = {6'd0, row_r} << 6;
      default: row_sh = 12'd0;
    endcase
    addr = row_sh + {4'd0, idx};
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    for (int i = 0; i < MAX_STRENGTH; i++) pos_nxt[i] = pos_r[i];
    row_nxt       = row_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    clr_row_nxt   = clr_row_r;
    clr_fin_nxt   = clr_fin_r;
    walk_fin_nxt  = walk_fin_r;
    uncov_nxt     = uncov_r;
    tot_nxt       = tot_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    newly_nxt     = newly_r;
    rem_out_nxt   = rem_out_r;
    tot_out_nxt   = tot_out_r;
    err_nxt       = err_r;
    cmd_ready     = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = clr_row_r;
    mem_wd        = '0;
    case (state_r)
      ST_INIT: begin
        mem_we      = 1'b1;
        clr_row_nxt = clr_row_r + 6'd1;
        if (clr_row_r == 6'(MAP_ROWS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_ready = cmd_valid;
        if (cmd_valid) begin
          cmd_nxt = cmd;
          for (int i = 0; i < MAX_STRENGTH; i++) pos_nxt[i] = 3'(i);
          row_nxt      = 6'd0;
          cnt_nxt      = 6'd0;
          acc_nxt      = 12'd0;
          clr_row_nxt  = 6'd0;
          clr_fin_nxt  = 1'b0;
          walk_fin_nxt = empty;
          case (cmd.kind)
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_ERROR: state_nxt = ST_DONE;
            default:   state_nxt = empty ? ST_DONE : ST_READ;
          endcase
        end
      end
      ST_CLEAR: begin
        if (!clr_fin_r) begin
          mem_we      = 1'b1;
          clr_row_nxt = clr_row_r + 6'd1;
          if (clr_row_r == 6'(MAP_ROWS - 1)) clr_fin_nxt = 1'b1;
        end
        if (!walk_fin_r) begin
          acc_nxt = acc_r + {4'd0, prod};
          for (int i = 0; i < MAX_STRENGTH; i++) pos_nxt[i] = pos_adv[i];
          if (!more) walk_fin_nxt = 1'b1;
        end
        if (clr_fin_r && walk_fin_r) begin
          tot_nxt   = acc_r;
          uncov_nxt = acc_r;
          state_nxt = ST_DONE;
        end
      end
      ST_READ: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!rdw_r[bit_r]) begin
          cnt_nxt = cnt_r + 6'd1;
          if (cmd_r.kind == CMD_COMMIT) begin
            mem_we = 1'b1;
            mem_wa = wa_r;
            mem_wd = rdw_r | (64'd1 << bit_r);
            if (uncov_r != 12'd0) uncov_nxt = uncov_r - 12'd1;
          end
        end
        for (int i = 0; i < MAX_STRENGTH; i++) pos_nxt[i] = pos_adv[i];
        row_nxt   = row_r + 6'd1;
        state_nxt = more ? ST_READ : ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          newly_nxt     = cnt_r;
          rem_out_nxt   = uncov_r;
          tot_out_nxt   = tot_r;
          err_nxt       = (cmd_r.kind == CMD_ERROR);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_row_r   <= 6'd0;
      clr_fin_r   <= 1'b0;
      walk_fin_r  <= 1'b0;
      uncov_r     <= 12'd0;
      tot_r       <= 12'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      clr_fin_r   <= clr_fin_nxt;
      walk_fin_r  <= walk_fin_nxt;
      uncov_r     <= uncov_nxt;
      tot_r       <= tot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    for (int i = 0; i < MAX_STRENGTH; i++) pos_r[i] <= pos_nxt[i];
    row_r     <= row_nxt;
    cnt_r     <= cnt_nxt;
    acc_r     <= acc_nxt;
    newly_r   <= newly_nxt;
    rem_out_r <= rem_out_nxt;
    tot_out_r <= tot_out_nxt;
    err_r     <= err_nxt;
  end

  // bitmap: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (state_r == ST_READ) begin
      rdw_r <= mem[addr[11:6]];
      wa_r  <= addr[11:6];
      bit_r <= addr[5:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign newly_covered = newly_r;
  assign remaining     = rem_out_r;
  assign total         = tot_out_r;
  assign error         = err_r;

endmodule

>>> src/tway_coverage_tracker.sv
// t-way coverage tracker: evaluate reads the bitmap word of each parameter subset (READ)
// and checks its bit (CHECK); commit also sets that bit with a read-modify-write
// clear is a sweep of the 56 bitmap words alongside the total count
// a 2-entry queue lets the next transaction be taken while one is in work
// after reset the 56 bitmap words are swept before the first transaction is started
// top level: configuration registers, front and back; depends on tct_pkg
module tway_coverage_tracker import tct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // test_vector[15:0]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // newly_covered[5:0], remaining[17:6], total[29:18], zeros
  output logic        out_tuser,  // error
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t        cfg_r;
  logic        wr;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;
  logic [5:0]  newly;
  logic [11:0] rem, tot;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.param_count  <= 4'd8;
      cfg_r.strength     <= 2'd2;
      cfg_r.level_counts <= 16'hFFFF;
    end else if (wr) begin
      case (cfg_paddr[3:2])
        REG_PARAM_COUNT: cfg_r.param_count  <= cfg_pwdata[3:0];
        REG_STRENGTH:    cfg_r.strength     <= cfg_pwdata[1:0];
        REG_LEVELS:      cfg_r.level_counts <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_PARAM_COUNT: cfg_prdata = {28'd0, cfg_r.param_count};
      REG_STRENGTH:    cfg_prdata = {30'd0, cfg_r.strength};
      REG_LEVELS:      cfg_prdata = {16'd0, cfg_r.level_counts};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  tct_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .action      (in_tuser),
    .test_vector (in_tdata),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_ready   (cmd_ready)
  );

  tct_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_ready     (cmd_ready),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .newly_covered (newly),
    .remaining     (rem),
    .total         (tot),
    .error         (out_tuser)
  );

  assign out_tdata = {2'b00, tot, rem, newly};

endmodule
